[sv/tle_pkg.sv]
// Shared types, constants and display-form helpers of the terminal line editor.
package tle_pkg;

	localparam int LINE_DEPTH = 32;
	localparam int LEN_W      = $clog2(LINE_DEPTH + 1);
	localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_ECHO = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EDIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAW  = 2'd2;

	localparam logic [7:0] KEY_INTR   = 8'h03;
	localparam logic [7:0] KEY_EOF    = 8'h04;
	localparam logic [7:0] KEY_BS     = 8'h08;
	localparam logic [7:0] KEY_CR     = 8'h0D;
	localparam logic [7:0] KEY_LF     = 8'h0A;
	localparam logic [7:0] KEY_REDRAW = 8'h12;
	localparam logic [7:0] KEY_KILL   = 8'h15;
	localparam logic [7:0] KEY_QUOTE  = 8'h16;
	localparam logic [7:0] KEY_WERASE = 8'h17;
	localparam logic [7:0] KEY_SUSP   = 8'h1A;
	localparam logic [7:0] KEY_ABORT  = 8'h1C;
	localparam logic [7:0] KEY_DEL    = 8'h7F;

	localparam logic [2:0] SPC_KILL  = 3'd0;
	localparam logic [2:0] SPC_INTR  = 3'd1;
	localparam logic [2:0] SPC_SUSP  = 3'd2;
	localparam logic [2:0] SPC_ABORT = 3'd3;
	localparam logic [2:0] SPC_EOF   = 3'd4;

	// "^R" CR LF
	localparam logic [31:0] REDRAW_HEAD = 32'h0A0D525E;
	localparam logic [31:0] CRLF_ECHO   = 32'h00000A0D;

	typedef struct packed {
		logic        send_valid;
		logic [7:0]  send_byte;
		logic        special_valid;
		logic [2:0]  special_code;
		logic [2:0]  echo_len;
		logic [31:0] echo_bytes;
		logic [2:0]  erase_columns;
		logic        last;
	} tle_result_t;

	typedef struct packed {
		logic [2:0]  len;
		logic [31:0] bytes;
	} tle_show_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] d);
		return (d < 4'd10) ? (8'h30 + {4'h0, d}) : (8'h37 + {4'h0, d});
	endfunction

	function automatic tle_show_t show_form(input logic [7:0] c);
		tle_show_t  s;
		logic [7:0] second;
		if ((c >= 8'd32 && c <= 8'd126) || c >= 8'd160) begin
			s.len   = 3'd1;
			s.bytes = {24'h0, c};
		end else if (c < 8'd128) begin
			second  = (c == KEY_DEL) ? 8'h3F : (c + 8'h40);
			s.len   = 3'd2;
			s.bytes = {16'h0, second, 8'h5E};
		end else begin
			s.len   = 3'd4;
			s.bytes = {8'h3E, hex_digit(c[3:0]), hex_digit(c[7:4]), 8'h3C};
		end
		return s;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

endpackage

[sv/tle_out_buf.sv]
// One-entry result register between the sequencer and the output channel.
module tle_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tle_pkg::tle_result_t res,
	output logic                space,
	output logic                out_valid,
	input  logic                out_ready,
	output tle_pkg::tle_result_t data
);
	import tle_pkg::*;

	logic        valid_q;
	tle_result_t data_q;

	assign space     = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign data      = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push && space) begin
			data_q <= res;
		end
	end

endmodule

[sv/terminal_line_editor.sv]
// Top level of the terminal line editor: line store, sequencer and config registers.
// Each accepted key byte is handled by a sequencer around a 32-entry line store with
// registered reads. An ordinary byte is stored while idle and, with echo on, echoed from
// the echo state; quote-next only sets the quote flag. Erase, word erase, line kill, redraw,
// end of file, return and the pass-through flush walk the stored line one entry per cycle
// while the output register has space: such an item passes a load state, then the walk,
// with the redraw header before the load and the closing send or the line events after
// the walk. A finished result waits in the output register while the sequencer moves on.
// New key bytes are taken only when the sequencer is idle.
module terminal_line_editor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [tle_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic                          cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    key_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          send_valid,
	output logic [7:0]                    send_byte,
	output logic                          special_valid,
	output logic [2:0]                    special_code,
	output logic [2:0]                    echo_len,
	output logic [31:0]                   echo_bytes,
	output logic [2:0]                    erase_columns,
	output logic                          last
);
	import tle_pkg::*;

	localparam logic [3:0] OP_PASS   = 4'd0;
	localparam logic [3:0] OP_BS     = 4'd1;
	localparam logic [3:0] OP_WORD   = 4'd2;
	localparam logic [3:0] OP_KILL   = 4'd3;
	localparam logic [3:0] OP_REDRAW = 4'd4;
	localparam logic [3:0] OP_QUOTE  = 4'd5;
	localparam logic [3:0] OP_EOF    = 4'd6;
	localparam logic [3:0] OP_RET    = 4'd7;
	localparam logic [3:0] OP_STORE  = 4'd8;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_LOAD  = 4'd1;
	localparam logic [3:0] S_WALK  = 4'd2;
	localparam logic [3:0] S_HEAD  = 4'd3;
	localparam logic [3:0] S_ECHO1 = 4'd4;
	localparam logic [3:0] S_PKEY  = 4'd5;
	localparam logic [3:0] S_CR    = 4'd6;
	localparam logic [3:0] S_LF    = 4'd7;
	localparam logic [3:0] S_SPEC0 = 4'd8;
	localparam logic [3:0] S_SPEC1 = 4'd9;

	logic [3:0]       state_q;
	logic [3:0]       op_q;
	logic [7:0]       key_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] cnt_q;
	logic             quote_q;
	logic             echo_q;
	logic             edit_q;
	logic             raw_q;

	logic [7:0]       mem [LINE_DEPTH];
	logic [7:0]       rd_a_s1;
	logic [7:0]       rd_b_s1;

	logic             accept;
	logic [3:0]       op_dec;
	logic [3:0]       post_state;
	logic             walk_erase;
	logic             walk_done;
	logic             emit;
	logic             go;
	logic             space;
	tle_result_t      res;
	tle_result_t      out_data;
	tle_show_t        show_a;
	tle_show_t        show_b;
	tle_show_t        show_k;
	logic [LEN_W-1:0] nx_cnt;
	logic [LEN_W-1:0] nx_len;
	logic [LEN_W-1:0] addr_a;
	logic [LEN_W-1:0] addr_b;
	logic             rd_en;
	logic             wr_en;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		if (!edit_q) begin
			op_dec = OP_PASS;
		end else if (quote_q) begin
			op_dec = OP_STORE;
		end else begin
			case (key_byte) inside
				KEY_BS, KEY_DEL:                        op_dec = OP_BS;
				KEY_WERASE:                             op_dec = OP_WORD;
				KEY_KILL, KEY_INTR, KEY_ABORT, KEY_SUSP: op_dec = OP_KILL;
				KEY_REDRAW:                             op_dec = OP_REDRAW;
				KEY_QUOTE:                              op_dec = OP_QUOTE;
				KEY_EOF:                                op_dec = OP_EOF;
				KEY_CR:                                 op_dec = OP_RET;
				default:                                op_dec = OP_STORE;
			endcase
		end
	end

	always_comb begin
		case (op_q)
			OP_PASS: post_state = S_PKEY;
			OP_RET:  post_state = S_CR;
			OP_KILL: post_state = S_SPEC0;
			default: post_state = S_IDLE;
		endcase
	end

	assign walk_erase = (op_q == OP_BS) || (op_q == OP_WORD) || (op_q == OP_KILL);
	assign show_a     = show_form(rd_a_s1);
	assign show_b     = show_form(rd_b_s1);
	assign show_k     = show_form(key_q);

	always_comb begin
		if (walk_erase) begin
			walk_done = (len_q == LEN_W'(1)) || (op_q == OP_BS) ||
				((op_q == OP_WORD) && is_blank(rd_b_s1) && !is_blank(rd_a_s1));
		end else begin
			walk_done = ((cnt_q + LEN_W'(1)) == len_q);
		end
	end

	always_comb begin
		res  = '0;
		emit = 1'b0;
		unique case (state_q)
			S_WALK: begin
				case (op_q) inside
					OP_PASS: begin
						emit              = 1'b1;
						res.send_valid    = 1'b1;
						res.send_byte     = rd_a_s1;
						res.erase_columns = show_b.len;
					end
					OP_BS, OP_WORD, OP_KILL: begin
						emit              = echo_q;
						res.erase_columns = show_a.len;
						res.last          = (op_q != OP_KILL) && walk_done;
					end
					OP_REDRAW: begin
						emit           = 1'b1;
						res.echo_len   = show_a.len;
						res.echo_bytes = show_a.bytes;
						res.last       = walk_done;
					end
					OP_EOF: begin
						emit           = 1'b1;
						res.send_valid = 1'b1;
						res.send_byte  = rd_a_s1;
						res.last       = walk_done;
					end
					default: begin
						emit           = 1'b1;
						res.send_valid = 1'b1;
						res.send_byte  = rd_a_s1;
					end
				endcase
			end
			S_HEAD: begin
				emit           = 1'b1;
				res.echo_len   = 3'd4;
				res.echo_bytes = REDRAW_HEAD;
				res.last       = (len_q == '0);
			end
			S_ECHO1: begin
				emit           = 1'b1;
				res.echo_len   = show_k.len;
				res.echo_bytes = show_k.bytes;
				res.last       = 1'b1;
			end
			S_PKEY: begin
				emit           = 1'b1;
				res.send_valid = 1'b1;
				res.send_byte  = key_q;
				res.echo_len   = echo_q ? 3'd1 : 3'd0;
				res.echo_bytes = echo_q ? {24'h0, key_q} : 32'h0;
				res.last       = 1'b1;
			end
			S_CR: begin
				emit           = 1'b1;
				res.send_valid = 1'b1;
				res.send_byte  = KEY_CR;
				res.echo_len   = (echo_q && !raw_q) ? 3'd2 : 3'd0;
				res.echo_bytes = (echo_q && !raw_q) ? CRLF_ECHO : 32'h0;
				res.last       = !raw_q;
			end
			S_LF: begin
				emit           = 1'b1;
				res.send_valid = 1'b1;
				res.send_byte  = KEY_LF;
				res.echo_len   = echo_q ? 3'd2 : 3'd0;
				res.echo_bytes = echo_q ? CRLF_ECHO : 32'h0;
				res.last       = 1'b1;
			end
			S_SPEC0: begin
				emit              = 1'b1;
				res.special_valid = 1'b1;
				res.special_code  = SPC_KILL;
				res.last          = (key_q == KEY_KILL);
			end
			S_SPEC1: begin
				emit              = 1'b1;
				res.special_valid = 1'b1;
				case (key_q)
					KEY_INTR:  res.special_code = SPC_INTR;
					KEY_SUSP:  res.special_code = SPC_SUSP;
					KEY_ABORT: res.special_code = SPC_ABORT;
					default:   res.special_code = SPC_EOF;
				endcase
				res.last = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign go = !emit || space;

	// read addresses for the entry the walk looks at next
	always_comb begin
		if (state_q == S_LOAD) begin
			nx_cnt = '0;
			nx_len = len_q;
			rd_en  = (len_q != '0);
		end else begin
			nx_cnt = cnt_q + LEN_W'(1);
			nx_len = walk_erase ? (len_q - LEN_W'(1)) : len_q;
			rd_en  = (state_q == S_WALK) && go;
		end
		addr_a = walk_erase ? (nx_len - LEN_W'(1)) : nx_cnt;
		addr_b = walk_erase ? (nx_len - LEN_W'(2)) : (len_q - LEN_W'(1) - nx_cnt);
	end

	assign wr_en = accept && (op_dec == OP_STORE) && (len_q < LEN_W'(LINE_DEPTH));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[len_q[IDX_W-1:0]] <= key_byte;
		end
		if (rd_en) begin
			rd_a_s1 <= mem[addr_a[IDX_W-1:0]];
			rd_b_s1 <= mem[addr_b[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_q <= 1'b1;
			edit_q <= 1'b1;
			raw_q  <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_ECHO: echo_q <= cfg_data;
				CFG_EDIT: edit_q <= cfg_data;
				CFG_RAW:  raw_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_PASS;
			key_q   <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
			quote_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q <= key_byte;
						op_q  <= op_dec;
						case (op_dec)
							OP_QUOTE: quote_q <= 1'b1;
							OP_STORE: begin
								quote_q <= 1'b0;
								if (wr_en) begin
									len_q <= len_q + LEN_W'(1);
									if (echo_q) begin
										state_q <= S_ECHO1;
									end
								end
							end
							OP_REDRAW: begin
								if (echo_q) begin
									state_q <= S_HEAD;
								end
							end
							OP_EOF: begin
								state_q <= (len_q == '0) ? S_SPEC1 : S_LOAD;
							end
							default: state_q <= S_LOAD;
						endcase
					end
				end
				S_LOAD: begin
					cnt_q   <= '0;
					state_q <= (len_q != '0) ? S_WALK : post_state;
				end
				S_WALK: begin
					if (go) begin
						if (walk_erase) begin
							len_q <= len_q - LEN_W'(1);
						end else begin
							cnt_q <= cnt_q + LEN_W'(1);
						end
						if (walk_done) begin
							if (op_q == OP_PASS || op_q == OP_EOF || op_q == OP_RET) begin
								len_q <= '0;
							end
							state_q <= post_state;
						end
					end
				end
				S_HEAD: begin
					if (go) begin
						state_q <= S_LOAD;
					end
				end
				S_CR: begin
					if (go) begin
						state_q <= raw_q ? S_LF : S_IDLE;
					end
				end
				S_SPEC0: begin
					if (go) begin
						state_q <= (key_q == KEY_KILL) ? S_IDLE : S_SPEC1;
					end
				end
				S_ECHO1, S_PKEY, S_LF, S_SPEC1: begin
					if (go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	tle_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit),
		.res       (res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.data      (out_data)
	);

	assign send_valid    = out_data.send_valid;
	assign send_byte     = out_data.send_byte;
	assign special_valid = out_data.special_valid;
	assign special_code  = out_data.special_code;
	assign echo_len      = out_data.echo_len;
	assign echo_bytes    = out_data.echo_bytes;
	assign erase_columns = out_data.erase_columns;
	assign last          = out_data.last;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(LINE_DEPTH))
		else $error("line length beyond depth");

	a_erase_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK && walk_erase) |-> (len_q != '0))
		else $error("erase walk on empty line");

	a_quote_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(quote_q) |-> $past(accept))
		else $error("quote flag set without a transfer");

	a_store_grows: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (len_q == $past(len_q) + LEN_W'(1)))
		else $error("store write without length update");

	a_walk_fwd_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK && !walk_erase) |-> (cnt_q < len_q))
		else $error("forward walk past line end");

endmodule

[bench/terminal_line_editor_checker.sv]
// Scoreboard for the terminal line editor: tracks the line state, predicts results, compares.
module terminal_line_editor_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [tle_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic                          cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [7:0]                    key_byte,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic                          send_valid,
	input  logic [7:0]                    send_byte,
	input  logic                          special_valid,
	input  logic [2:0]                    special_code,
	input  logic [2:0]                    echo_len,
	input  logic [31:0]                   echo_bytes,
	input  logic [2:0]                    erase_columns,
	input  logic                          last,
	output int                            errors,
	output int                            pending
);
	import tle_pkg::*;

	localparam logic [7:0] CARET  = 8'h5E;
	localparam logic [7:0] QMARK  = 8'h3F;
	localparam logic [7:0] LANGLE = 8'h3C;
	localparam logic [7:0] RANGLE = 8'h3E;

	logic [7:0]  line_buf [LINE_DEPTH];
	int          fill;
	logic        quoted;
	logic        echo_on;
	logic        edit_on;
	logic        crlf_on;
	int          err_count = 0;
	tle_result_t awaited_results [$];
	tle_result_t key_results [$];

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
	endfunction

	// {length, bytes} of the on-screen form, first byte in the low bits
	function automatic logic [34:0] render(input logic [7:0] c);
		logic [7:0] second;
		second = (c == KEY_DEL) ? QMARK : c + 8'h40;
		if ((c >= 8'h20 && c <= 8'h7E) || c >= 8'hA0)
			return {3'd1, 24'h0, c};
		if (c < 8'h80)
			return {3'd2, 16'h0, second, CARET};
		return {3'd4, RANGLE, hex_char(c[3:0]), hex_char(c[7:4]), LANGLE};
	endfunction

	function automatic logic [2:0] width_of(input logic [7:0] c);
		logic [34:0] f;
		f = render(c);
		return f[34:32];
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	task automatic add_result(input logic sv, input logic [7:0] sb, input logic spv,
			input logic [2:0] spc, input logic [34:0] echo, input logic [2:0] cols);
		tle_result_t r;
		r.send_valid    = sv;
		r.send_byte     = sb;
		r.special_valid = spv;
		r.special_code  = spc;
		r.echo_len      = echo[34:32];
		r.echo_bytes    = echo[31:0];
		r.erase_columns = cols;
		r.last          = 1'b0;
		key_results.push_back(r);
	endtask

	task automatic erase_one();
		if (fill == 0)
			return;
		if (echo_on)
			add_result(1'b0, 8'h0, 1'b0, 3'd0, 35'd0, width_of(line_buf[fill-1]));
		fill--;
	endtask

	task automatic send_all();
		for (int i = 0; i < fill; i++)
			add_result(1'b1, line_buf[i], 1'b0, 3'd0, 35'd0, 3'd0);
		fill = 0;
	endtask

	task automatic store_key(input logic [7:0] c);
		if (fill < LINE_DEPTH) begin
			line_buf[fill] = c;
			fill++;
			if (echo_on)
				add_result(1'b0, 8'h0, 1'b0, 3'd0, render(c), 3'd0);
		end
		quoted = 1'b0;
	endtask

	task automatic predict_key(input logic [7:0] c);
		int          n;
		logic [7:0]  gone;
		tle_result_t r;
		key_results = {};
		if (!edit_on) begin
			n = fill;
			for (int i = 0; i < n; i++)
				add_result(1'b1, line_buf[i], 1'b0, 3'd0, 35'd0, width_of(line_buf[n-1-i]));
			fill = 0;
			add_result(1'b1, c, 1'b0, 3'd0, echo_on ? {3'd1, 24'h0, c} : 35'd0, 3'd0);
		end else if (quoted) begin
			store_key(c);
		end else begin
			case (c)
				KEY_BS, KEY_DEL: erase_one();
				KEY_WERASE: begin
					while (fill > 0) begin
						gone = line_buf[fill-1];
						erase_one();
						if (fill > 0 && is_space(line_buf[fill-1]) && !is_space(gone))
							break;
					end
				end
				KEY_KILL, KEY_INTR, KEY_ABORT, KEY_SUSP: begin
					while (fill > 0)
						erase_one();
					add_result(1'b0, 8'h0, 1'b1, SPC_KILL, 35'd0, 3'd0);
					if (c == KEY_INTR)
						add_result(1'b0, 8'h0, 1'b1, SPC_INTR, 35'd0, 3'd0);
					if (c == KEY_SUSP)
						add_result(1'b0, 8'h0, 1'b1, SPC_SUSP, 35'd0, 3'd0);
					if (c == KEY_ABORT)
						add_result(1'b0, 8'h0, 1'b1, SPC_ABORT, 35'd0, 3'd0);
				end
				KEY_REDRAW: begin
					if (echo_on) begin
						add_result(1'b0, 8'h0, 1'b0, 3'd0, {3'd4, REDRAW_HEAD}, 3'd0);
						for (int i = 0; i < fill; i++)
							add_result(1'b0, 8'h0, 1'b0, 3'd0, render(line_buf[i]), 3'd0);
					end
				end
				KEY_QUOTE: quoted = 1'b1;
				KEY_EOF: begin
					if (fill == 0)
						add_result(1'b0, 8'h0, 1'b1, SPC_EOF, 35'd0, 3'd0);
					else
						send_all();
				end
				KEY_CR: begin
					send_all();
					if (crlf_on) begin
						add_result(1'b1, KEY_CR, 1'b0, 3'd0, 35'd0, 3'd0);
						add_result(1'b1, KEY_LF, 1'b0, 3'd0,
							echo_on ? {3'd2, CRLF_ECHO} : 35'd0, 3'd0);
					end else begin
						add_result(1'b1, KEY_CR, 1'b0, 3'd0,
							echo_on ? {3'd2, CRLF_ECHO} : 35'd0, 3'd0);
					end
				end
				default: store_key(c);
			endcase
		end
		if (key_results.size() > 0) begin
			r = key_results.pop_back();
			r.last = 1'b1;
			key_results.push_back(r);
		end
		foreach (key_results[i])
			awaited_results.push_back(key_results[i]);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			err_count++;
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		tle_result_t want;
		if (!arst_n) begin
			fill            = 0;
			quoted          = 1'b0;
			echo_on         = 1'b1;
			edit_on         = 1'b1;
			crlf_on         = 1'b0;
			awaited_results = {};
			errors  <= err_count;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					err_count++;
					$display("%0t: transfer with none expected, send %b/%h echo %0d/%h",
						$time, send_valid, send_byte, echo_len, echo_bytes);
				end else begin
					want = awaited_results.pop_front();
					check_field("send_valid", want.send_valid, send_valid);
					check_field("send_byte", want.send_byte, send_byte);
					check_field("special_valid", want.special_valid, special_valid);
					check_field("special_code", want.special_code, special_code);
					check_field("echo_len", want.echo_len, echo_len);
					check_field("echo_bytes", want.echo_bytes, echo_bytes);
					check_field("erase_columns", want.erase_columns, erase_columns);
					check_field("last", want.last, last);
				end
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_ECHO: echo_on = cfg_data;
					CFG_EDIT: edit_on = cfg_data;
					CFG_RAW:  crlf_on = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predict_key(key_byte);
			errors  <= err_count;
			pending <= awaited_results.size();
		end
	end

endmodule

[bench/terminal_line_editor_tb.sv]
// Testbench top for the terminal line editor: clock, reset, key stimulus and verdict.
module terminal_line_editor_tb;
	import tle_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = LINE_DEPTH + 16;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic                 cfg_data = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [7:0]           key_byte = 8'h0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 send_valid;
	logic [7:0]           send_byte;
	logic                 special_valid;
	logic [2:0]           special_code;
	logic [2:0]           echo_len;
	logic [31:0]          echo_bytes;
	logic [2:0]           erase_columns;
	logic                 last;
	int                   errors;
	int                   pending;
	int                   cycle_count = 0;
	int                   keys_sent = 0;
	logic                 calm = 1'b0;
	logic                 hold_sink = 1'b0;

	terminal_line_editor dut (.*);

	terminal_line_editor_checker checker_i (.*);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// result side: short random stalls, one long hold-off on request
	initial begin : sink
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_sink && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// leaves in_valid high after the transfer
	task automatic send_key(input logic [7:0] b);
		int gap;
		gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		key_byte <= b;
		do @(posedge clk); while (!in_ready);
		keys_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_mode(input logic echo, input logic edit, input logic crlf);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_ECHO;
		cfg_data  <= echo;
		@(posedge clk);
		cfg_index <= CFG_EDIT;
		cfg_data  <= edit;
		@(posedge clk);
		cfg_index <= CFG_RAW;
		cfg_data  <= crlf;
		@(posedge clk);
		cfg_index <= CFG_SPARE;
		cfg_data  <= 1'($urandom_range(0, 1));
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// mostly short lines; now and then one long enough to overflow the store
	task automatic type_line();
		int n;
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, LINE_DEPTH + 4)
			: $urandom_range(0, 10);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 19))
				0: send_key(8'($urandom_range(0, 255)));
				1: begin
					send_key(KEY_QUOTE);
					send_key(($urandom_range(0, 3) == 0) ? KEY_DEL : 8'($urandom_range(0, 31)));
				end
				2: send_key($urandom_range(0, 1) ? KEY_BS : KEY_DEL);
				3: send_key(KEY_WERASE);
				4: send_key(KEY_REDRAW);
				5, 6, 7: send_key(8'h20);
				default: send_key(8'($urandom_range(8'h21, 8'h7E)));
			endcase
		end
		case ($urandom_range(0, 8))
			0, 1, 2: send_key(KEY_CR);
			3: send_key(KEY_EOF);
			4: send_key(KEY_KILL);
			5: send_key(KEY_INTR);
			6: send_key(KEY_SUSP);
			7: send_key(KEY_ABORT);
			default: ;
		endcase
	endtask

	task automatic type_lines(input int count);
		int stop;
		stop = keys_sent + count;
		while (keys_sent < stop)
			type_line();
	endtask

	// pending text of mixed display widths, so a later flush has work
	task automatic leave_text();
		send_key(8'h71);
		send_key(8'h01);
		send_key(8'h85);
	endtask

	initial begin
		logic [7:0] opening [25];
		opening = '{8'h61, 8'h00, 8'h80, 8'hFF, 8'hA0, 8'h7E, 8'h9F,
			KEY_REDRAW, KEY_BS, KEY_DEL, 8'h20, 8'h62, KEY_WERASE,
			KEY_QUOTE, KEY_CR, KEY_EOF, KEY_EOF, 8'h78, KEY_INTR,
			8'h79, KEY_SUSP, KEY_ABORT, KEY_KILL, 8'h7A, KEY_CR};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i])
			send_key(opening[i]);
		settle();

		apply_mode(1'b1, 1'b1, 1'b1);
		hold_sink <= 1'b1;
		type_lines(12);
		settle();

		apply_mode(1'b0, 1'b1, 1'b0);
		type_lines(12);
		leave_text();
		settle();

		apply_mode(1'b1, 1'b0, 1'b0);
		type_lines(12);
		settle();

		apply_mode(1'b1, 1'b1, 1'b0);
		type_lines(12);
		leave_text();
		settle();

		apply_mode(1'b0, 1'b0, 1'b1);
		type_lines(10);
		settle();

		apply_mode(1'b1, 1'b1, 1'b0);
		calm <= 1'b1;
		type_lines(12);
		settle();

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
